// ----- hdl/bopt_pkg.sv -----
`default_nettype none
package bopt_pkg;

  localparam int FIELD_BITS     = 16;
  localparam int COUNT_OUT_BITS = 7;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_DATA_BITS-1:0] PALLET_WIDTH_RESET  = 16'd1200;
  localparam logic [CFG_DATA_BITS-1:0] PALLET_LENGTH_RESET = 16'd800;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PALLET_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PALLET_LENGTH = 1'b1;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [FIELD_BITS-1:0] corner_x;
    logic [FIELD_BITS-1:0] corner_y;
    logic [FIELD_BITS-1:0] corner_z;
    logic [FIELD_BITS-1:0] size_x;
    logic [FIELD_BITS-1:0] size_y;
    logic [FIELD_BITS-1:0] size_z;
  } request_t;

  typedef struct packed {
    logic                      placeable;
    logic [COUNT_OUT_BITS-1:0] stored_count;
    logic                      overflow;
  } result_t;

  // Control part of the token that walks down the cell chain.
  typedef struct packed {
    logic valid;
    logic store;
    logic ok;
    logic overflow;
  } ctl_t;

endpackage
`default_nettype wire

// ----- hdl/box_overlap_placement_table.sv -----
// A request travels from the accepting edge to the result through the entry register
// and then one register per box cell in the chain.
// Throughput: one request per cycle; every request walks the whole chain in order.
// Reset clears the box count, the pipeline valids and the pallet registers (1200, 800);
// box storage is not cleared. Results cannot be held off: done is a one-cycle strobe.
`default_nettype none
module box_overlap_placement_table
  import bopt_pkg::*;
#(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire request_t                  request,
  output logic                           done,
  output result_t                        result,
  input  wire logic                      wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] wr_index,
  input  wire logic [CFG_DATA_BITS-1:0]  wr_data
);

  localparam int CB = COORD_BITS;
  localparam int NB = $clog2(MAX_BOXES + 1);
  localparam int SW = (CB + 1 > CFG_DATA_BITS + 1) ? CB + 1 : CFG_DATA_BITS + 1;

  logic [CFG_DATA_BITS-1:0] pallet_width;
  logic [CFG_DATA_BITS-1:0] pallet_length;
  logic [NB-1:0]            count;
  logic [NB-1:0]            count_next;

  ctl_t            head_ctl;
  logic [3*CB-1:0] head_lo;
  logic [3*CB+2:0] head_hi;
  logic [NB-1:0]   head_count;

  ctl_t            chain_ctl   [0:MAX_BOXES];
  logic [3*CB-1:0] chain_lo    [0:MAX_BOXES];
  logic [3*CB+2:0] chain_hi    [0:MAX_BOXES];
  logic [NB-1:0]   chain_count [0:MAX_BOXES];

  logic            accept;
  logic            is_store;
  logic            full;
  logic            fits;
  logic [CB-1:0]   lo_x, lo_y, lo_z;
  logic [CB:0]     hi_x, hi_y, hi_z;

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    lo_x = CB'(request.corner_x);
    lo_y = CB'(request.corner_y);
    lo_z = CB'(request.corner_z);
    hi_x = {1'b0, lo_x} + {1'b0, CB'(request.size_x)};
    hi_y = {1'b0, lo_y} + {1'b0, CB'(request.size_y)};
    hi_z = {1'b0, lo_z} + {1'b0, CB'(request.size_z)};
    fits = (SW'(hi_x) <= SW'(pallet_width)) && (SW'(hi_y) <= SW'(pallet_length));
    is_store = (request.kind == KIND_STORE);
    full     = (count == NB'(MAX_BOXES));
    count_next = count;
    if (accept && is_store && !full) begin
      count_next = count + NB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pallet_width  <= PALLET_WIDTH_RESET;
      pallet_length <= PALLET_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PALLET_WIDTH:  pallet_width  <= wr_data;
        REG_PALLET_LENGTH: pallet_length <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      head_ctl <= '0;
    end else begin
      count             <= count_next;
      head_ctl.valid    <= accept;
      head_ctl.store    <= is_store;
      head_ctl.ok       <= !is_store && fits;
      head_ctl.overflow <= is_store && full;
    end
  end

  // Count after this request rides along; stores write the cell at count - 1.
  always_ff @(posedge clk) begin
    head_lo    <= {lo_z, lo_y, lo_x};
    head_hi    <= {hi_z, hi_y, hi_x};
    head_count <= count_next;
  end

  assign chain_ctl[0]   = head_ctl;
  assign chain_lo[0]    = head_lo;
  assign chain_hi[0]    = head_hi;
  assign chain_count[0] = head_count;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    bopt_cell #(
      .CB  (CB),
      .NB  (NB),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_ctl    (chain_ctl[i]),
      .in_lo     (chain_lo[i]),
      .in_hi     (chain_hi[i]),
      .in_count  (chain_count[i]),
      .out_ctl   (chain_ctl[i+1]),
      .out_lo    (chain_lo[i+1]),
      .out_hi    (chain_hi[i+1]),
      .out_count (chain_count[i+1])
    );
  end

  assign done                = chain_ctl[MAX_BOXES].valid;
  assign result.placeable    = chain_ctl[MAX_BOXES].ok;
  assign result.stored_count = COUNT_OUT_BITS'(chain_count[MAX_BOXES]);
  assign result.overflow     = chain_ctl[MAX_BOXES].overflow;

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, MAX_BOXES + 1))
    else $error("done without a request accepted MAX_BOXES+1 cycles earlier");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= NB'(MAX_BOXES))
    else $error("box count above table depth");

  a_full_store_holds_count: assert property (@(posedge clk) disable iff (rst)
    (accept && is_store && full) |=> (count == NB'(MAX_BOXES)))
    else $error("dropped store changed the box count");

  a_store_never_placeable: assert property (@(posedge clk) disable iff (rst)
    (done && chain_ctl[MAX_BOXES].store) |-> !result.placeable)
    else $error("store request reported placeable");

endmodule
`default_nettype wire

// ----- hdl/bopt_cell.sv -----
`default_nettype none
module bopt_cell
  import bopt_pkg::*;
#(
  parameter int CB  = 16,
  parameter int NB  = 7,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_t              in_ctl,
  input  wire logic [3*CB-1:0]   in_lo,
  input  wire logic [3*CB+2:0]   in_hi,
  input  wire logic [NB-1:0]     in_count,
  output ctl_t                   out_ctl,
  output logic [3*CB-1:0]        out_lo,
  output logic [3*CB+2:0]        out_hi,
  output logic [NB-1:0]          out_count
);

  // Stored box: corner and far corner (corner + size), one bit wider.
  logic [3*CB-1:0] box_lo;
  logic [3*CB+2:0] box_hi;

  logic [2:0] axis_hit;
  logic       hit;
  logic       write;
  ctl_t       ctl_next;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_hit[a] = ({1'b0, in_lo[a*CB +: CB]} < box_hi[a*(CB+1) +: CB+1]) &&
                    (in_hi[a*(CB+1) +: CB+1] > {1'b0, box_lo[a*CB +: CB]});
    end
    // only boxes stored before this query count
    hit   = in_ctl.valid && !in_ctl.store && (NB'(IDX) < in_count) && (&axis_hit);
    write = in_ctl.valid && in_ctl.store && !in_ctl.overflow &&
            (in_count == NB'(IDX + 1));
    ctl_next    = in_ctl;
    ctl_next.ok = in_ctl.ok && !hit;
  end

  always_ff @(posedge clk) begin
    if (write) begin
      box_lo <= in_lo;
      box_hi <= in_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    out_lo    <= in_lo;
    out_hi    <= in_hi;
    out_count <= in_count;
  end

endmodule
`default_nettype wire
